// File: design/pbm_pkg.sv
// ----------------------------------------------------------------------------
// pbm_pkg
// Shared types, widths and codes for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pbm_pkg;

   localparam int ADDR_W     = 64;
   localparam int CNT_W      = 14;
   localparam int PCT_W      = 7;
   localparam int STAT_W     = 32;
   localparam int IDX_OUT_W  = 13;
   localparam int PAGE_SHIFT = 12;
   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;
   localparam int PROD_W     = 21;
   localparam int QUO_W      = 8;
   localparam int STEP_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int PCT_SCALE  = 100;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_PAGES = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_REL_CHK,
      ST_REL_BIT,
      ST_PRESS,
      ST_DONE
   } st_type;

   typedef enum logic [1:0] {
      PCT_IDLE,
      PCT_MUL,
      PCT_DIV
   } pct_st_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] live;
      logic [CNT_W-1:0] pages;
   } pct_req_type;

   typedef struct packed {
      logic             done;
      logic [PCT_W-1:0] pct;
   } pct_rsp_type;

   function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
      return (&v) ? v : v + STAT_W'(1);
   endfunction

endpackage

// File: design/pbm_if.sv
// ----------------------------------------------------------------------------
// pbm_if
// Valid/ready channels of the page bitmap allocator: request and response.
// ----------------------------------------------------------------------------
interface pbm_req_if import pbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [ADDR_W-1:0] release_addr;

   modport source (output valid, kind, release_addr, input ready);
   modport sink   (input valid, kind, release_addr, output ready);
endinterface

interface pbm_rsp_if import pbm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 ok;
   logic [ADDR_W-1:0]    granted_addr;
   logic [IDX_OUT_W-1:0] page_index;
   logic [CNT_W-1:0]     live_pages;
   logic [CNT_W-1:0]     live_peak;
   logic [PCT_W-1:0]     peak_pressure_pct;
   logic [STAT_W-1:0]    alloc_tries;
   logic [STAT_W-1:0]    alloc_wins;
   logic [STAT_W-1:0]    release_tries;
   logic [STAT_W-1:0]    release_wins;
   logic [STAT_W-1:0]    pool_full_count;
   logic [ADDR_W-1:0]    last_granted;

   modport source (output valid, ok, granted_addr, page_index, live_pages, live_peak,
                   peak_pressure_pct, alloc_tries, alloc_wins, release_tries,
                   release_wins, pool_full_count, last_granted,
                   input ready);
   modport sink   (input valid, ok, granted_addr, page_index, live_pages, live_peak,
                   peak_pressure_pct, alloc_tries, alloc_wins, release_tries,
                   release_wins, pool_full_count, last_granted,
                   output ready);
endinterface

// File: design/pbm_ram.sv
// ----------------------------------------------------------------------------
// pbm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pbm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/pbm_pct.sv
// ----------------------------------------------------------------------------
// pbm_pct
// Pressure unit: live*100/pages by one multiply and an 8-step restoring
// division, result capped at 100.
// ----------------------------------------------------------------------------
module pbm_pct import pbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  pct_req_type req,
   output pct_rsp_type rsp
);

   pct_st_type        st_ff, st_in;
   logic [CNT_W-1:0]  pages_ff, pages_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]  q_ff, q_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] div_sh;

   assign div_sh = PROD_W'(pages_ff) << step_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         PCT_IDLE: if (req.start) st_in = PCT_MUL;
         PCT_MUL:  st_in = PCT_DIV;
         PCT_DIV:  if (step_ff == '0) st_in = PCT_IDLE;
         default:  st_in = PCT_IDLE;
      endcase
   end

   always_comb begin
      pages_in = pages_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      unique case (st_ff)
         PCT_IDLE: begin
            if (req.start) begin
               pages_in = req.pages;
               rem_in   = PROD_W'(req.live);
            end
         end
         PCT_MUL: begin
            rem_in  = PROD_W'(rem_ff[CNT_W-1:0] * PROD_W'(PCT_SCALE));
            q_in    = '0;
            step_in = STEP_W'(QUO_W - 1);
         end
         PCT_DIV: begin
            if (rem_ff >= div_sh) begin
               rem_in        = rem_ff - div_sh;
               q_in[step_ff] = 1'b1;
            end
            step_in = step_ff - STEP_W'(1);
            done_in = (step_ff == '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= PCT_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      pages_ff <= pages_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      step_ff  <= step_in;
   end

   assign rsp.done = done_ff;
   assign rsp.pct  = (q_ff > QUO_W'(PCT_SCALE)) ? PCT_W'(PCT_SCALE) : PCT_W'(q_ff);

endmodule

// File: design/page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Next-fit 4 KiB page allocator over a used-bit map held in a word RAM.
//
//   channel   dir  handshake        payload
//   req_chan  in   valid/ready      kind, release_addr
//   rsp_chan  out  valid/ready      ok, granted_addr, page_index, stats
//   csr_*     in   csr_we           csr_index, csr_wdata
//
// One transaction at a time. Release: a check state reads the map word, then
// a bit state clears the used bit; the bit state is skipped when the checks fail.
// Allocate: each 32-page map word scanned (at most words+1 words) is read and
// then checked, the pressure divider runs on a grant, and when the hint must
// be reduced after a shrink it is first reduced modulo the page count.
// After reset the map RAM is cleared, one word a cycle; no request is taken
// meanwhile. A finished response waits in the output register while the next
// request is accepted.
// ----------------------------------------------------------------------------
module page_bitmap_allocator import pbm_pkg::*; #(
   parameter int MAX_PAGES = 8192
) (
   input  logic                 clock,
   input  logic                 reset,
   pbm_req_if.sink              req_chan,
   pbm_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   localparam int NW    = (MAX_PAGES + WORD_W - 1) / WORD_W;
   localparam int WA_W  = (NW > 1) ? $clog2(NW) : 1;
   localparam int PW    = WA_W + BIT_W;
   localparam int CW    = ((PW > CNT_W) ? PW : CNT_W) + 1;
   localparam int RW    = CNT_W + 1;
   localparam int RC_W  = $clog2(PW);
   localparam int CAP   = (MAX_PAGES > 16383) ? 16383 : MAX_PAGES;

   st_type              state_ff, state_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]    pages_ff, pages_in;
   logic [WA_W-1:0]     clr_ff, clr_in;
   logic [PW-1:0]       hint_ff, hint_in;
   logic [PW-1:0]       start_ff, start_in;
   logic [WA_W-1:0]     w_ff, w_in;
   logic                phase_ff, phase_in;
   logic [RW-1:0]       rem_ff, rem_in;
   logic [RC_W-1:0]     rcnt_ff, rcnt_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [PW-1:0]       pidx_ff, pidx_in;
   logic                ok_ff, ok_in;
   logic [ADDR_W-1:0]   granted_ff, granted_in;
   logic [CNT_W-1:0]    live_ff, live_in;
   logic [CNT_W-1:0]    wmark_ff, wmark_in;
   logic [PCT_W-1:0]    peak_ff, peak_in;
   logic [STAT_W-1:0]   at_ff, at_in, aw_ff, aw_in, rt_ff, rt_in, rw_ff, rw_in;
   logic [STAT_W-1:0]   full_ff, full_in;
   logic [ADDR_W-1:0]   last_ff, last_in;

   logic                 rv_ff, rv_in;
   logic                 r_ok_ff;
   logic [ADDR_W-1:0]    r_granted_ff, r_last_ff;
   logic [IDX_OUT_W-1:0] r_pidx_ff;
   logic [CNT_W-1:0]     r_live_ff, r_wmark_ff;
   logic [PCT_W-1:0]     r_peak_ff;
   logic [STAT_W-1:0]    r_at_ff, r_aw_ff, r_rt_ff, r_rw_ff, r_full_ff;
   logic                 rsp_load;

   logic                ram_we, ram_re;
   logic [WA_W-1:0]     ram_wa, ram_ra;
   logic [WORD_W-1:0]   ram_wd, ram_rd;

   pct_req_type         pct_req;
   pct_rsp_type         pct_rsp;

   logic [CNT_W-1:0]    p_eff;
   logic                configured;
   logic [PW-1:0]       lastp;
   logic [WA_W-1:0]     ws, wl;
   logic [BIT_W-1:0]    sb, lb;
   logic [WORD_W-1:0]   free_mask;
   logic                found;
   logic [BIT_W-1:0]    fb;
   logic [PW-1:0]       found_idx;
   logic [CW-1:0]       nh_sum;
   logic [ADDR_W-1:0]   rel;
   logic                rel_ok;
   logic [PW-1:0]       rel_idx;
   logic                accept;

   pbm_ram #(.WIDTH(WORD_W), .DEPTH(NW)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   pbm_pct u_pct (
      .clock (clock),
      .reset (reset),
      .req   (pct_req),
      .rsp   (pct_rsp)
   );

   assign p_eff      = (pages_ff > CNT_W'(CAP)) ? CNT_W'(CAP) : pages_ff;
   assign configured = (p_eff != '0) && (base_ff != '0);
   assign lastp      = PW'(p_eff - CNT_W'(1));
   assign ws         = start_ff[PW-1:BIT_W];
   assign wl         = lastp[PW-1:BIT_W];
   assign sb         = start_ff[BIT_W-1:0];
   assign lb         = lastp[BIT_W-1:0];
   assign accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      logic in_p, in_s;
      free_mask = '0;
      fb        = '0;
      for (int b = 0; b < WORD_W; b++) begin
         in_p = (w_ff < wl) || (BIT_W'(b) <= lb);
         in_s = phase_ff ? ((w_ff < ws) || (BIT_W'(b) < sb))
                         : ((w_ff > ws) || (BIT_W'(b) >= sb));
         free_mask[b] = !ram_rd[b] && in_p && in_s;
      end
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (free_mask[b]) fb = BIT_W'(b);
      end
   end

   assign found     = |free_mask;
   assign found_idx = {w_ff, fb};
   assign nh_sum    = CW'(found_idx) + CW'(1);

   assign rel     = addr_ff - base_ff;
   assign rel_ok  = configured && (addr_ff >= base_ff)
                    && (addr_ff[PAGE_SHIFT-1:0] == '0) && (rel[PAGE_SHIFT-1:0] == '0)
                    && (rel[ADDR_W-1:PAGE_SHIFT] < (ADDR_W - PAGE_SHIFT)'(p_eff));
   assign rel_idx = rel[PAGE_SHIFT +: PW];

   // configuration
   always_comb begin
      base_in  = base_ff;
      pages_in = pages_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_POOL_BASE:  base_in  = csr_wdata;
            CSR_POOL_PAGES: pages_in = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == WA_W'(NW - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.kind == KIND_RELEASE) state_in = ST_REL_CHK;
               else if (!configured)              state_in = ST_DONE;
               else if (CW'(hint_ff) >= CW'(p_eff)) state_in = ST_REDUCE;
               else                               state_in = ST_SCAN_RD;
            end
         end
         ST_REDUCE:   if (rcnt_ff == '0) state_in = ST_SCAN_RD;
         ST_SCAN_RD:  state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (found)                          state_in = ST_PRESS;
            else if (phase_ff && (w_ff == ws))  state_in = ST_DONE;
            else                                state_in = ST_SCAN_RD;
         end
         ST_REL_CHK:  state_in = rel_ok ? ST_REL_BIT : ST_DONE;
         ST_REL_BIT:  state_in = ST_DONE;
         ST_PRESS:    if (pct_rsp.done) state_in = ST_DONE;
         ST_DONE:     if (!rv_ff || rsp_chan.ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      logic [RW-1:0] t;
      logic [PW-1:0] rs;
      clr_in     = clr_ff;
      hint_in    = hint_ff;
      start_in   = start_ff;
      w_in       = w_ff;
      phase_in   = phase_ff;
      rem_in     = rem_ff;
      rcnt_in    = rcnt_ff;
      addr_in    = addr_ff;
      pidx_in    = pidx_ff;
      ok_in      = ok_ff;
      granted_in = granted_ff;
      live_in    = live_ff;
      wmark_in   = wmark_ff;
      peak_in    = peak_ff;
      at_in      = at_ff;
      aw_in      = aw_ff;
      rt_in      = rt_ff;
      rw_in      = rw_ff;
      full_in    = full_ff;
      last_in    = last_ff;
      ram_we     = 1'b0;
      ram_wa     = w_ff;
      ram_wd     = '0;
      ram_re     = 1'b0;
      ram_ra     = w_ff;
      pct_req    = '0;
      rsp_load   = 1'b0;
      t          = '0;
      rs         = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff;
            clr_in = clr_ff + WA_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               addr_in    = req_chan.release_addr;
               ok_in      = 1'b0;
               granted_in = '0;
               pidx_in    = '0;
               if (req_chan.kind == KIND_RELEASE) begin
                  rt_in = sat_inc(rt_ff);
               end else begin
                  at_in    = sat_inc(at_ff);
                  start_in = hint_ff;
                  w_in     = hint_ff[PW-1:BIT_W];
                  phase_in = 1'b0;
                  rem_in   = '0;
                  rcnt_in  = RC_W'(PW - 1);
               end
            end
         end
         ST_REDUCE: begin
            t = {rem_ff[RW-2:0], hint_ff[rcnt_ff]};
            if (t >= RW'(p_eff)) t = t - RW'(p_eff);
            rem_in   = t;
            rcnt_in  = rcnt_ff - RC_W'(1);
            rs       = PW'(t);
            start_in = rs;
            w_in     = rs[PW-1:BIT_W];
         end
         ST_SCAN_RD: begin
            ram_re = 1'b1;
            ram_ra = w_ff;
         end
         ST_SCAN_CHK: begin
            if (found) begin
               ram_we        = 1'b1;
               ram_wa        = w_ff;
               ram_wd        = ram_rd | (WORD_W'(1) << fb);
               pidx_in       = found_idx;
               hint_in       = (nh_sum == CW'(p_eff)) ? '0 : PW'(nh_sum);
               aw_in         = sat_inc(aw_ff);
               live_in       = live_ff + CNT_W'(1);
               wmark_in      = (live_in > wmark_ff) ? live_in : wmark_ff;
               ok_in         = 1'b1;
               pct_req.start = 1'b1;
               pct_req.live  = live_in;
               pct_req.pages = p_eff;
            end else if (!phase_ff) begin
               if (w_ff == wl) begin
                  phase_in = 1'b1;
                  w_in     = '0;
               end else begin
                  w_in = w_ff + WA_W'(1);
               end
            end else if (w_ff == ws) begin
               full_in = sat_inc(full_ff);
            end else begin
               w_in = w_ff + WA_W'(1);
            end
         end
         ST_REL_CHK: begin
            pidx_in = rel_idx;
            ram_re  = rel_ok;
            ram_ra  = rel_idx[PW-1:BIT_W];
         end
         ST_REL_BIT: begin
            ram_wa = pidx_ff[PW-1:BIT_W];
            if (ram_rd[pidx_ff[BIT_W-1:0]]) begin
               ram_we  = 1'b1;
               ram_wd  = ram_rd & ~(WORD_W'(1) << pidx_ff[BIT_W-1:0]);
               live_in = (live_ff != '0) ? live_ff - CNT_W'(1) : live_ff;
               rw_in   = sat_inc(rw_ff);
               ok_in   = 1'b1;
            end
         end
         ST_PRESS: begin
            if (pct_rsp.done) begin
               if (pct_rsp.pct > peak_ff) peak_in = pct_rsp.pct;
               granted_in = base_ff + (ADDR_W'(pidx_ff) << PAGE_SHIFT);
               last_in    = granted_in;
            end
         end
         ST_DONE: begin
            rsp_load = !rv_ff || rsp_chan.ready;
         end
         default: ;
      endcase
   end

   assign rv_in = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rv_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         base_ff  <= '0;
         pages_ff <= '0;
         clr_ff   <= '0;
         hint_ff  <= '0;
         live_ff  <= '0;
         wmark_ff <= '0;
         peak_ff  <= '0;
         at_ff    <= '0;
         aw_ff    <= '0;
         rt_ff    <= '0;
         rw_ff    <= '0;
         full_ff  <= '0;
         last_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         pages_ff <= pages_in;
         clr_ff   <= clr_in;
         hint_ff  <= hint_in;
         live_ff  <= live_in;
         wmark_ff <= wmark_in;
         peak_ff  <= peak_in;
         at_ff    <= at_in;
         aw_ff    <= aw_in;
         rt_ff    <= rt_in;
         rw_ff    <= rw_in;
         full_ff  <= full_in;
         last_ff  <= last_in;
         rv_ff    <= rv_in;
      end
      start_ff   <= start_in;
      w_ff       <= w_in;
      phase_ff   <= phase_in;
      rem_ff     <= rem_in;
      rcnt_ff    <= rcnt_in;
      addr_ff    <= addr_in;
      pidx_ff    <= pidx_in;
      ok_ff      <= ok_in;
      granted_ff <= granted_in;
      if (rsp_load) begin
         r_ok_ff      <= ok_ff;
         r_granted_ff <= granted_ff;
         r_pidx_ff    <= ok_ff ? IDX_OUT_W'(pidx_ff) : '0;
         r_live_ff    <= live_ff;
         r_wmark_ff   <= wmark_ff;
         r_peak_ff    <= peak_ff;
         r_at_ff      <= at_ff;
         r_aw_ff      <= aw_ff;
         r_rt_ff      <= rt_ff;
         r_rw_ff      <= rw_ff;
         r_full_ff    <= full_ff;
         r_last_ff    <= last_ff;
      end
   end

   assign req_chan.ready             = (state_ff == ST_IDLE);
   assign rsp_chan.valid             = rv_ff;
   assign rsp_chan.ok                = r_ok_ff;
   assign rsp_chan.granted_addr      = r_granted_ff;
   assign rsp_chan.page_index        = r_pidx_ff;
   assign rsp_chan.live_pages        = r_live_ff;
   assign rsp_chan.live_peak         = r_wmark_ff;
   assign rsp_chan.peak_pressure_pct = r_peak_ff;
   assign rsp_chan.alloc_tries       = r_at_ff;
   assign rsp_chan.alloc_wins        = r_aw_ff;
   assign rsp_chan.release_tries     = r_rt_ff;
   assign rsp_chan.release_wins      = r_rw_ff;
   assign rsp_chan.pool_full_count   = r_full_ff;
   assign rsp_chan.last_granted      = r_last_ff;

endmodule

// File: verif/page_bitmap_allocator_tb.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator_tb
// Self-checking bench for the next-fit page allocator. A scoreboard tracks
// the used-page map, hint, live count, watermark, pressure and statistics,
// predicts every response and compares it field by field. Directed cases
// cover the unconfigured pool, a full pool, bad releases, address wrap, an
// unaligned base, shrinking the pool and one long response stall. Random pools
// of mixed size follow, two runs of three under random stalls on both channels.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_tb;
   import pbm_pkg::*;

   localparam int POOL_DEPTH = 8192;

   typedef struct {
      logic                 ok;
      logic [ADDR_W-1:0]    granted_addr;
      logic [IDX_OUT_W-1:0] page_index;
      logic [CNT_W-1:0]     live_pages;
      logic [CNT_W-1:0]     live_peak;
      logic [PCT_W-1:0]     peak_pressure_pct;
      logic [STAT_W-1:0]    alloc_tries;
      logic [STAT_W-1:0]    alloc_wins;
      logic [STAT_W-1:0]    release_tries;
      logic [STAT_W-1:0]    release_wins;
      logic [STAT_W-1:0]    pool_full_count;
      logic [ADDR_W-1:0]    last_granted;
   } page_outcome_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_wdata;

   pbm_req_if req_bus ();
   pbm_rsp_if rsp_bus ();

   page_bitmap_allocator #(.MAX_PAGES(POOL_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // scoreboard copy of the allocator
   bit                page_used [POOL_DEPTH];
   int unsigned       scan_hint;
   int unsigned       live_cnt;
   int unsigned       peak_live;
   int unsigned       peak_pct;
   logic [STAT_W-1:0] alloc_try_cnt;
   logic [STAT_W-1:0] alloc_win_cnt;
   logic [STAT_W-1:0] free_try_cnt;
   logic [STAT_W-1:0] free_win_cnt;
   logic [STAT_W-1:0] full_cnt;
   logic [ADDR_W-1:0] last_grant;
   logic [ADDR_W-1:0] pool_base;
   logic [CNT_W-1:0]  pool_pages;

   page_outcome_type outcomes_due [$];

   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   logic        stall_rsp;
   int unsigned mismatches;
   int unsigned ops_sent;
   int unsigned pool_settings;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $error("timeout: run did not complete");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [STAT_W-1:0] sat_bump(input logic [STAT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int unsigned eff_pool_pages();
      return (pool_pages > POOL_DEPTH) ? POOL_DEPTH : int'(pool_pages);
   endfunction

   function automatic void apply_page_op(input logic kind, input logic [ADDR_W-1:0] addr);
      page_outcome_type  o;
      int unsigned       pages;
      int unsigned       idx;
      int unsigned       n;
      bit                configured;
      logic [ADDR_W-1:0] rel;
      logic [ADDR_W-1:0] rel_idx;
      longint unsigned   pct;
      pages      = eff_pool_pages();
      configured = (pages != 0) && (pool_base != '0);
      o.ok           = 1'b0;
      o.granted_addr = '0;
      o.page_index   = '0;
      if (kind == KIND_ALLOC) begin
         alloc_try_cnt = sat_bump(alloc_try_cnt);
         if (configured) begin
            for (n = 0; n < pages; n++) begin
               idx = (scan_hint + n) % pages;
               if (!page_used[idx]) begin
                  page_used[idx] = 1'b1;
                  scan_hint      = (idx + 1) % pages;
                  alloc_win_cnt  = sat_bump(alloc_win_cnt);
                  live_cnt++;
                  if (live_cnt > peak_live) peak_live = live_cnt;
                  pct = (longint'(live_cnt) * PCT_SCALE) / pages;
                  if (pct > PCT_SCALE) pct = PCT_SCALE;
                  if (pct > peak_pct) peak_pct = int'(pct);
                  o.granted_addr = pool_base + (ADDR_W'(idx) << PAGE_SHIFT);
                  o.page_index   = idx[IDX_OUT_W-1:0];
                  o.ok           = 1'b1;
                  last_grant     = o.granted_addr;
                  break;
               end
            end
            if (!o.ok) full_cnt = sat_bump(full_cnt);
         end
      end else begin
         free_try_cnt = sat_bump(free_try_cnt);
         if (configured && addr >= pool_base && addr[PAGE_SHIFT-1:0] == '0) begin
            rel     = addr - pool_base;
            rel_idx = rel >> PAGE_SHIFT;
            if (rel[PAGE_SHIFT-1:0] == '0 && rel_idx < pages &&
                page_used[rel_idx[IDX_OUT_W-1:0]]) begin
               page_used[rel_idx[IDX_OUT_W-1:0]] = 1'b0;
               if (live_cnt > 0) live_cnt--;
               free_win_cnt = sat_bump(free_win_cnt);
               o.page_index = rel_idx[IDX_OUT_W-1:0];
               o.ok         = 1'b1;
            end
         end
      end
      o.live_pages        = CNT_W'(live_cnt);
      o.live_peak         = CNT_W'(peak_live);
      o.peak_pressure_pct = PCT_W'(peak_pct);
      o.alloc_tries       = alloc_try_cnt;
      o.alloc_wins        = alloc_win_cnt;
      o.release_tries     = free_try_cnt;
      o.release_wins      = free_win_cnt;
      o.pool_full_count   = full_cnt;
      o.last_granted      = last_grant;
      outcomes_due.push_back(o);
   endfunction

   // address of some used page in the pool, a free one if none is used, or a random address for an empty pool
   function automatic logic [ADDR_W-1:0] pick_used_page();
      int unsigned pages;
      int unsigned start;
      int unsigned idx;
      int unsigned n;
      pages = eff_pool_pages();
      if (pages == 0) return rand64();
      start = $urandom_range(0, pages - 1);
      for (n = 0; n < pages; n++) begin
         idx = (start + n) % pages;
         if (page_used[idx]) return pool_base + (ADDR_W'(idx) << PAGE_SHIFT);
      end
      return pool_base + (ADDR_W'(start) << PAGE_SHIFT);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      page_outcome_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (outcomes_due.size() == 0) begin
            $error("response transaction with nothing outstanding");
            mismatches++;
         end else begin
            want = outcomes_due.pop_front();
            check_field("ok", want.ok, rsp_bus.ok);
            check_field("granted_addr", want.granted_addr, rsp_bus.granted_addr);
            check_field("page_index", want.page_index, rsp_bus.page_index);
            check_field("live_pages", want.live_pages, rsp_bus.live_pages);
            check_field("live_peak", want.live_peak, rsp_bus.live_peak);
            check_field("peak_pressure_pct", want.peak_pressure_pct,
                        rsp_bus.peak_pressure_pct);
            check_field("alloc_tries", want.alloc_tries, rsp_bus.alloc_tries);
            check_field("alloc_wins", want.alloc_wins, rsp_bus.alloc_wins);
            check_field("release_tries", want.release_tries, rsp_bus.release_tries);
            check_field("release_wins", want.release_wins, rsp_bus.release_wins);
            check_field("pool_full_count", want.pool_full_count, rsp_bus.pool_full_count);
            check_field("last_granted", want.last_granted, rsp_bus.last_granted);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !stall_rsp && ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic send_op(input logic kind, input logic [ADDR_W-1:0] addr);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= kind;
      req_bus.release_addr <= addr;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      apply_page_op(kind, addr);
      ops_sent++;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outcomes_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] pages_word);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_POOL_BASE;
      csr_wdata <= base;
      @(posedge clock);
      pool_base  = base;
      csr_index <= CSR_POOL_PAGES;
      csr_wdata <= pages_word;
      @(posedge clock);
      pool_pages = pages_word[CNT_W-1:0];
      csr_we    <= 1'b0;
      pool_settings++;
   endtask

   task automatic test_unconfigured();
      send_op(KIND_ALLOC, '0);
      send_op(KIND_RELEASE, '0);
      set_pool('0, 64'd4);
      send_op(KIND_ALLOC, '1);
      set_pool(64'h0000_0000_0010_0000, '0);
      send_op(KIND_RELEASE, 64'h0000_0000_0010_0000);
   endtask

   task automatic test_pool_full();
      logic [ADDR_W-1:0] b;
      b = 64'h0000_0000_4000_0000;
      // upper data bits set: only the low 14 bits reach the register
      set_pool(b, 64'hFFFF_FFFF_FFFF_C003);
      repeat (4) send_op(KIND_ALLOC, rand64());
      send_op(KIND_RELEASE, b + 64'h1000);
      send_op(KIND_RELEASE, b + 64'h1000);
      send_op(KIND_RELEASE, b + 64'h1800);
      send_op(KIND_RELEASE, '0);
      send_op(KIND_RELEASE, '1);
      send_op(KIND_RELEASE, b + 64'h3000);
      send_op(KIND_ALLOC, rand64());
   endtask

   task automatic test_address_wrap();
      logic [ADDR_W-1:0] b;
      b = 64'hFFFF_FFFF_FFFF_E000;
      set_pool(b, 64'd5);
      send_op(KIND_ALLOC, rand64());
      send_op(KIND_RELEASE, last_grant);
      send_op(KIND_RELEASE, b);
   endtask

   task automatic test_unaligned_base();
      set_pool(64'h0000_0000_0001_2345, 64'd4);
      send_op(KIND_ALLOC, rand64());
      send_op(KIND_RELEASE, last_grant);
   endtask

   // pages beyond the map depth are capped; shrinking leaves live above the
   // page count and the hint past the end
   task automatic test_shrink();
      logic [ADDR_W-1:0] b;
      b = 64'h0000_0000_8000_0000;
      set_pool(b, 64'd12000);
      repeat (3) send_op(KIND_ALLOC, rand64());
      set_pool(b, 64'd2);
      send_op(KIND_RELEASE, b + 64'h1000);
      send_op(KIND_ALLOC, rand64());
   endtask

   task automatic test_backpressure();
      req_idle_pct  = 0;
      rsp_idle_pct <= 0;
      set_pool(64'h0000_0002_0000_0000, 64'd32);
      fork
         begin
            stall_rsp <= 1'b1;
            repeat (300) @(posedge clock);
            stall_rsp <= 1'b0;
         end
         begin
            for (int i = 0; i < 16; i++) begin
               if (i % 3 == 2) send_op(KIND_RELEASE, pick_used_page());
               else send_op(KIND_ALLOC, rand64());
            end
         end
      join
      wait_idle();
      for (int i = 0; i < 8; i++) begin
         if ($urandom_range(0, 1)) send_op(KIND_RELEASE, pick_used_page());
         else send_op(KIND_ALLOC, rand64());
      end
   endtask

   task automatic test_random(input int unsigned n_ops, input int unsigned snd_idle,
                              input int unsigned rcv_idle);
      int unsigned       done_ops;
      int unsigned       burst;
      int unsigned       r;
      int unsigned       pages;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] noise;
      req_idle_pct  = snd_idle;
      rsp_idle_pct <= rcv_idle;
      done_ops = 0;
      while (done_ops < n_ops) begin
         r = $urandom_range(0, 99);
         if (r < 70) pages = $urandom_range(1, 40);
         else if (r < 85) pages = $urandom_range(41, 400);
         else if (r < 90) pages = 0;
         else if (r < 95) pages = POOL_DEPTH;
         else pages = $urandom_range(POOL_DEPTH + 1, 16383);
         r = $urandom_range(0, 99);
         if (r < 80) base = rand64() & ~64'hFFF;
         else if (r < 88) base = rand64();
         else if (r < 94) base = 64'hFFFF_FFFF_FFFF_F000 -
                                 (ADDR_W'($urandom_range(0, 20)) << PAGE_SHIFT);
         else base = '0;
         noise = rand64();
         set_pool(base, {noise[ADDR_W-1:CNT_W], CNT_W'(pages)});
         burst = $urandom_range(20, 80);
         repeat (burst) begin
            r = $urandom_range(0, 99);
            if (r < 48) send_op(KIND_ALLOC, rand64());
            else if (r < 85) send_op(KIND_RELEASE, pick_used_page());
            else if (r < 90) send_op(KIND_RELEASE, rand64());
            else if (r < 95) send_op(KIND_RELEASE,
                                     pick_used_page() + ADDR_W'($urandom_range(1, 'hFFF)));
            else send_op(KIND_RELEASE, pool_base +
                         ((ADDR_W'(eff_pool_pages()) + $urandom_range(0, 3)) << PAGE_SHIFT));
         end
         done_ops += burst;
      end
   endtask

   initial begin
      int unsigned guard;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_POOL_BASE;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.kind         = KIND_ALLOC;
      req_bus.release_addr = '0;
      stall_rsp            = 1'b0;
      req_idle_pct         = 29;
      rsp_idle_pct         = 64;
      mismatches           = 0;
      ops_sent             = 0;
      pool_settings        = 0;
      foreach (page_used[i]) page_used[i] = 1'b0;
      scan_hint     = 0;
      live_cnt      = 0;
      peak_live     = 0;
      peak_pct      = 0;
      alloc_try_cnt = '0;
      alloc_win_cnt = '0;
      free_try_cnt  = '0;
      free_win_cnt  = '0;
      full_cnt      = '0;
      last_grant    = '0;
      pool_base     = '0;
      pool_pages    = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_unconfigured();
      test_pool_full();
      test_address_wrap();
      test_unaligned_base();
      test_shrink();
      test_backpressure();
      test_random(330, 29, 64);
      test_random(330, 64, 29);
      test_random(330, 0, 0);

      req_bus.valid <= 1'b0;
      guard = 0;
      while (outcomes_due.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      if (outcomes_due.size() != 0) begin
         $error("%0d response transactions never arrived", outcomes_due.size());
         mismatches++;
      end
      repeat (600) @(posedge clock);

      $display("Ran %0d transactions over %0d pool settings.", ops_sent, pool_settings);
      $display("Grants %0d, frees %0d, pool-full allocations %0d.",
               alloc_win_cnt, free_win_cnt, full_cnt);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
